// ----- design/nsqrt_pkg.sv -----
// Shared types and constants of the Newton square root block.
package nsqrt_pkg;

	localparam int FRAC_BITS = 16;
	localparam int RAD_W     = 32;
	localparam int ROOT_W    = 24;
	localparam int GUESS_W   = 32;
	localparam int TOL_W     = 16;
	localparam int ITER_W    = 8;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 16;

	localparam logic [TOL_W-1:0]  TOL_RESET  = 16'd7;
	localparam logic [ITER_W-1:0] ITER_RESET = 8'd100;
	localparam logic [ROOT_W-1:0] ROOT_MAX   = {ROOT_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 1'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_UPDATE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic div_init;
		logic div_step;
		logic advance;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic div_last;
		logic converged;
		logic out_full;
	} status_t;

endpackage

// ----- design/nsqrt_if.sv -----
// Item channels of the Newton square root block.
interface nsqrt_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [nsqrt_pkg::RAD_W-1:0] radicand;

	modport source (output valid, output radicand, input ready);
	modport sink (input valid, input radicand, output ready);
endinterface

interface nsqrt_out_if;
	logic                         valid;
	logic                         ready;
	logic [nsqrt_pkg::ROOT_W-1:0] root;
	logic                         status;

	modport source (output valid, output root, output status, input ready);
	modport sink (input valid, input root, input status, output ready);
endinterface

// ----- design/nsqrt_ctrl.sv -----
// Sequencer of the Newton square root block.
module nsqrt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  nsqrt_pkg::status_t sts,
	output nsqrt_pkg::cmd_t    cmd
);

	nsqrt_pkg::state_t state_q;
	nsqrt_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nsqrt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			nsqrt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = nsqrt_pkg::ST_CHECK;
				end
			end
			nsqrt_pkg::ST_CHECK: begin
				if (sts.skip) begin
					state_d = nsqrt_pkg::ST_DONE;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = nsqrt_pkg::ST_DIV;
				end
			end
			nsqrt_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = nsqrt_pkg::ST_UPDATE;
				end
			end
			nsqrt_pkg::ST_UPDATE: begin
				if (sts.converged) begin
					state_d = nsqrt_pkg::ST_DONE;
				end else begin
					cmd.advance = 1'b1;
					state_d     = nsqrt_pkg::ST_CHECK;
				end
			end
			nsqrt_pkg::ST_DONE: begin
				if (!sts.out_full) begin
					cmd.emit = 1'b1;
					state_d  = nsqrt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = nsqrt_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- design/nsqrt_dp.sv -----
// Datapath of the Newton square root block: registers, divider, update, result.
module nsqrt_dp #(
	parameter int FRAC_BITS = nsqrt_pkg::FRAC_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [nsqrt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [nsqrt_pkg::CFG_W-1:0]           cfg_data,
	input  logic signed [nsqrt_pkg::RAD_W-1:0]    in_radicand,
	input  nsqrt_pkg::cmd_t                       cmd,
	output nsqrt_pkg::status_t                    sts,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [nsqrt_pkg::ROOT_W-1:0]          out_root,
	output logic                                  out_status
);

	localparam int GW    = nsqrt_pkg::GUESS_W;
	localparam int DW    = nsqrt_pkg::RAD_W + FRAC_BITS;
	localparam int CNT_W = $clog2(DW);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DW - 1);

	logic [nsqrt_pkg::TOL_W-1:0]  tol_q;
	logic [nsqrt_pkg::ITER_W-1:0] max_iter_q;
	logic [nsqrt_pkg::ITER_W-1:0] iter_q;
	logic [nsqrt_pkg::RAD_W-1:0]  rad_q;
	logic                         neg_q;
	logic                         zero_q;
	logic [GW-1:0]                guess_q;
	logic [GW-1:0]                rem_q;
	logic [DW-1:0]                quo_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         out_valid_q;
	logic [nsqrt_pkg::ROOT_W-1:0] root_q;
	logic                         status_q;

	logic [GW-1:0] dvs;
	logic [GW:0]   rem_sh;
	logic [GW:0]   rem_sub;
	logic          ge;
	logic [DW:0]   sum;
	logic [DW-1:0] next_g;
	logic [DW-1:0] guess_x;
	logic [DW-1:0] diff;
	logic [GW-1:0] start_g;
	logic [nsqrt_pkg::ROOT_W-1:0] sat_g;

	always_comb begin
		dvs     = (guess_q == '0) ? GW'(1) : guess_q;
		rem_sh  = {rem_q, quo_q[DW-1]};
		rem_sub = rem_sh - {1'b0, dvs};
		ge      = rem_sh >= {1'b0, dvs};
		guess_x = DW'(guess_q);
		sum     = {1'b0, quo_q} + {1'b0, guess_x};
		next_g  = sum[DW:1];
		diff    = (next_g >= guess_x) ? (next_g - guess_x) : (guess_x - next_g);
		start_g = {1'b0, in_radicand[nsqrt_pkg::RAD_W-1:1]};
		if (start_g == '0) begin
			start_g = GW'(1);
		end
		sat_g = (guess_q > GW'(nsqrt_pkg::ROOT_MAX)) ? nsqrt_pkg::ROOT_MAX
			: guess_q[nsqrt_pkg::ROOT_W-1:0];
	end

	assign sts.skip      = neg_q | zero_q | (iter_q == max_iter_q);
	assign sts.div_last  = cnt_q == CNT_LAST;
	assign sts.converged = diff < DW'(tol_q);
	assign sts.out_full  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q       <= nsqrt_pkg::TOL_RESET;
			max_iter_q  <= nsqrt_pkg::ITER_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					nsqrt_pkg::CFG_TOLERANCE: tol_q <= cfg_data[nsqrt_pkg::TOL_W-1:0];
					nsqrt_pkg::CFG_MAX_ITER: max_iter_q <= cfg_data[nsqrt_pkg::ITER_W-1:0];
					default: ;
				endcase
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rad_q   <= in_radicand;
			neg_q   <= in_radicand[nsqrt_pkg::RAD_W-1];
			zero_q  <= in_radicand == '0;
			guess_q <= start_g;
			iter_q  <= '0;
		end
		if (cmd.div_init) begin
			quo_q <= {rad_q, {FRAC_BITS{1'b0}}};
			rem_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? rem_sub[GW-1:0] : rem_sh[GW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (cmd.advance) begin
			guess_q <= next_g[GW-1:0];
			iter_q  <= iter_q + nsqrt_pkg::ITER_W'(1);
		end
		if (cmd.emit) begin
			root_q   <= (neg_q | zero_q) ? '0 : sat_g;
			status_q <= neg_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_root   = root_q;
	assign out_status = status_q;

endmodule

// ----- design/newton_square_root.sv -----
// A negative or zero radicand, or a reached iteration limit, sends CHECK on to DONE.
// Else each iteration runs the radix-2 divider, then UPDATE, which goes to DONE once the
// guess has converged and back to CHECK if not. DONE holds while the output is full.
// One item at a time: the next item is accepted the cycle after the result is loaded into
// the output register.
// Reset (arst_n low) returns to idle, empties the output register, tolerance 7, limit 100.
module newton_square_root #(
	parameter int FRAC_BITS = nsqrt_pkg::FRAC_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	nsqrt_in_if.sink                        req,
	nsqrt_out_if.source                     rsp,
	input  logic                            cfg_we,
	input  logic [nsqrt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nsqrt_pkg::CFG_W-1:0]     cfg_data
);

	nsqrt_pkg::cmd_t    cmd;
	nsqrt_pkg::status_t sts;

	nsqrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	nsqrt_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_radicand (req.radicand),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.out_root    (rsp.root),
		.out_status  (rsp.status)
	);

endmodule

// ----- design/nsqrt_checker.sv -----
// Port-level checks of the Newton square root block and their binding.
module nsqrt_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [nsqrt_pkg::ROOT_W-1:0] out_root,
	input logic                        out_status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_root) && $stable(out_status))
		else $error("result changed while stalled");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status |-> out_root == '0)
		else $error("rejected item with nonzero root");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while busy");

endmodule

bind newton_square_root nsqrt_checker u_nsqrt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (req.valid),
	.in_ready   (req.ready),
	.out_valid  (rsp.valid),
	.out_ready  (rsp.ready),
	.out_root   (rsp.root),
	.out_status (rsp.status)
);

// ----- bench/newton_square_root_tb.sv -----
// Self-checking testbench of the Newton square root block: directed and random radicands.
module newton_square_root_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 60000;
	localparam int HOLD_CYCLES    = 3000;

	typedef struct packed {
		logic [nsqrt_pkg::ROOT_W-1:0] root;
		logic                         status;
	} root_result_t;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [nsqrt_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [nsqrt_pkg::CFG_W-1:0]     cfg_data;

	nsqrt_in_if  req_ch ();
	nsqrt_out_if rsp_ch ();

	newton_square_root uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	logic [nsqrt_pkg::RAD_W-1:0] pending_radicands[$];
	root_result_t                expected_roots[$];
	root_result_t                oldest_root;

	logic [nsqrt_pkg::TOL_W-1:0]  tol_lsb;
	logic [nsqrt_pkg::ITER_W-1:0] iter_limit;

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	logic        rx_hold = 1'b0;

	int unsigned radicands_in    = 0;
	int unsigned roots_out       = 0;
	int unsigned negatives_in    = 0;
	int unsigned settings_run    = 0;
	int unsigned mismatch_count  = 0;
	int unsigned quiet_cycles    = 0;

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 40)
			$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	function automatic root_result_t predict_root(input logic [nsqrt_pkg::RAD_W-1:0] rad);
		root_result_t res;
		bit [63:0]    scaled;
		bit [63:0]    guess;
		bit [63:0]    refined;
		bit [63:0]    delta;
		int unsigned  k;
		res.root   = '0;
		res.status = rad[nsqrt_pkg::RAD_W-1];
		if (rad[nsqrt_pkg::RAD_W-1] || rad == '0)
			return res;
		scaled = 64'(rad) << nsqrt_pkg::FRAC_BITS;
		guess  = 64'(rad) >> 1;
		if (guess == 0)
			guess = 1;
		for (k = 0; k < iter_limit; k++) begin
			refined = (guess + scaled / (guess == 0 ? 64'd1 : guess)) >> 1;
			delta   = refined >= guess ? refined - guess : guess - refined;
			if (delta < 64'(tol_lsb))
				break;
			guess = refined;
		end
		res.root = guess > 64'(nsqrt_pkg::ROOT_MAX) ? nsqrt_pkg::ROOT_MAX
			: guess[nsqrt_pkg::ROOT_W-1:0];
		return res;
	endfunction

	function automatic logic [nsqrt_pkg::RAD_W-1:0] random_radicand();
		case ($urandom_range(9))
			0: return 32'h8000_0000 | $urandom;
			1: return $urandom_range(16);
			2: return $urandom_range(32'h0000_FFFF);
			3: return $urandom_range(32'h00FF_FFFF);
			default: return {1'b0, 31'($urandom)};
		endcase
	endfunction

	// sender
	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid    <= 1'b0;
			req_ch.radicand <= '0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (req_ch.valid) begin
				expected_roots.push_back(predict_root(req_ch.radicand));
				radicands_in <= radicands_in + 1;
				if (req_ch.radicand[nsqrt_pkg::RAD_W-1])
					negatives_in <= negatives_in + 1;
			end
			if (pending_radicands.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				req_ch.valid    <= 1'b1;
				req_ch.radicand <= pending_radicands.pop_front();
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				roots_out <= roots_out + 1;
				if (expected_roots.size() == 0) begin
					report_mismatch($sformatf("result root=%0h status=%0b with none expected",
						rsp_ch.root, rsp_ch.status));
				end else begin
					oldest_root = expected_roots.pop_front();
					if (rsp_ch.root !== oldest_root.root)
						report_mismatch($sformatf("root %0h, expected %0h",
							rsp_ch.root, oldest_root.root));
					if (rsp_ch.status !== oldest_root.status)
						report_mismatch($sformatf("status %0b, expected %0b",
							rsp_ch.status, oldest_root.status));
				end
			end
			rsp_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// long receiver hold-off so the block backs up onto its input
	initial begin
		wait (radicands_in >= 60);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic write_reg(input logic [nsqrt_pkg::CFG_IDX_W-1:0] idx,
		input logic [nsqrt_pkg::CFG_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		if (idx == nsqrt_pkg::CFG_TOLERANCE)
			tol_lsb = value;
		else
			iter_limit = value[nsqrt_pkg::ITER_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input logic [nsqrt_pkg::TOL_W-1:0] tol,
		input logic [nsqrt_pkg::ITER_W-1:0] iters);
		write_reg(nsqrt_pkg::CFG_TOLERANCE, tol);
		write_reg(nsqrt_pkg::CFG_MAX_ITER, {8'($urandom_range(255)), iters});
		settings_run++;
	endtask

	task automatic drain();
		do @(posedge clk);
		while (pending_radicands.size() != 0 || req_ch.valid || expected_roots.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_idling(input idle_mode_t mode);
		send_idle_pct  = (mode == IDLE_SENDER) ? 45 : (mode == IDLE_BOTH) ? 13 : 0;
		recv_stall_pct = (mode == IDLE_RECEIVER) ? 45 : (mode == IDLE_BOTH) ? 13 : 0;
	endtask

	task automatic run_random(input int unsigned count);
		idle_mode_t mode;
		mode = IDLE_NONE;
		repeat (4) begin
			set_idling(mode);
			repeat (count / 4) pending_radicands.push_back(random_radicand());
			drain();
			mode = idle_mode_t'(int'(mode) + 1);
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		tol_lsb         = nsqrt_pkg::TOL_RESET;
		iter_limit      = nsqrt_pkg::ITER_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		settings_run = 1;

		// reset settings: field extremes, bit patterns, negatives
		pending_radicands = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
			32'h0001_0000, 32'h0004_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
			32'h0000_8000, 32'h4000_0000, 32'h5555_5555, 32'h2AAA_AAAA, 32'hAAAA_AAAA};
		drain();
		// zero tolerance with the widest iteration limit
		configure(16'd0, 8'd255);
		pending_radicands = '{32'h7FFF_FFFF, 32'h0000_0001, 32'h0001_0000};
		drain();
		// no iterations at all: start guess returned, saturated when wide
		configure(16'hFFFF, 8'd0);
		pending_radicands = '{32'h7FFF_FFFF, 32'h0000_0005, 32'h0100_0000};
		drain();
		// one iteration leaves the guess of the largest radicand too wide
		configure(16'd7, 8'd1);
		pending_radicands = '{32'h7FFF_FFFF, 32'h0200_0000, 32'h0000_0100};
		drain();

		configure(nsqrt_pkg::TOL_RESET, nsqrt_pkg::ITER_RESET);
		run_random(400);
		configure(16'd0, 8'd4);
		run_random(200);
		configure(16'hFFFF, 8'd255);
		run_random(200);
		configure(16'($urandom_range(300)), 8'($urandom_range(1, 30)));
		run_random(200);
		configure(16'd0, 8'd0);
		run_random(160);
		configure(16'd1, 8'd40);
		run_random(100);
		configure(16'($urandom), 8'($urandom_range(1, 20)));
		run_random(200);
		repeat (100) @(posedge clk);

		$display("Covered %0d radicands (%0d negative) and %0d roots over %0d register settings.",
			radicands_in, negatives_in, roots_out, settings_run);
		$display("Idling ran with none, sender gaps, receiver stalls, both, and a long hold-off.");
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
